/* src/rcfp_pkg.sv */
// rcfp_pkg: shared constants and types for the RC receiver frame parser.
// No dependencies; imported by every module under src/.
package rcfp_pkg;

   localparam int FRAME_BYTES_DEF = 32;  // bytes per frame, header to checksum
   localparam int CHANNELS_DEF    = 8;   // channels refreshed per good frame

   localparam int POS_W       = 5;       // byte position within a frame (<= 32 bytes)
   localparam int PEND_DEPTH  = 16;      // frame bytes 2..17 kept for channel decode
   localparam int PEND_BASE   = 2;       // first payload byte position
   localparam int CHAN_FIELDS = 8;       // channel fields on the result port
   localparam int FS_PEND_IDX = 11;      // frame byte 13 holds the failsafe nibble

   localparam logic [7:0]  HDR_FIRST  = 8'h20;
   localparam logic [7:0]  HDR_SECOND = 8'h40;
   localparam logic [15:0] SUM_START  = 16'hFFFF;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] chan_type;

   // end-of-frame event from the parser to the result stage
   typedef struct packed {
      logic done;  // final frame byte consumed this cycle
      logic ok;    // checksum matched
   } frame_evt_type;

endpackage

/* src/rc_receiver_frame_parser_top.sv */
// rc_receiver_frame_parser_top: iBus-style frame decoder, one serial byte per beat.
// Depends on rcfp_pkg, rcfp_in_reg, rcfp_parse, rcfp_out_reg.
//
//   channel | ports                                 | direction | beat
//   --------+---------------------------------------+-----------+--------------------------
//   req     | req_valid, req_stall, req_rx_byte      | in        | one received byte
//   rsp     | rsp_valid, rsp_stall, rsp_frame_ok,    | out       | one per frame, on the
//           | rsp_chan_0..7, rsp_failsafe_bits       |           | final (checksum) byte
//
// Takes one byte per cycle while req_stall is low. A byte is held in the input
// register, then the parser updates position and checksum; the result beat
// shows up the cycle after the final frame byte was taken from the input register.
// Reset (synchronous) returns to hunting for the first header, checksum 0xFFFF,
// channels and failsafe zero.
// rsp_stall only holds back the final byte of a frame; other bytes keep flowing
// while a result waits.
module rc_receiver_frame_parser_top
   import rcfp_pkg::*;
#(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF,  // 20..32
   parameter int CHANNELS    = CHANNELS_DEF      // 1..8
) (
   input  logic        clock,
   input  logic        reset,
   // byte channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   // frame result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_frame_ok,
   output logic [15:0] rsp_chan_0,
   output logic [15:0] rsp_chan_1,
   output logic [15:0] rsp_chan_2,
   output logic [15:0] rsp_chan_3,
   output logic [15:0] rsp_chan_4,
   output logic [15:0] rsp_chan_5,
   output logic [15:0] rsp_chan_6,
   output logic [15:0] rsp_chan_7,
   output logic [3:0]  rsp_failsafe_bits
);

   logic          in_vld;
   byte_type      in_byte;
   logic          consume;
   logic          out_free;
   frame_evt_type evt;
   byte_type      pend [PEND_DEPTH];
   chan_type      chan [CHAN_FIELDS];

   // input register: decouples the source from the result stall
   rcfp_in_reg u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .consume     (consume),
      .vld         (in_vld),
      .rx_byte     (in_byte)
   );

   // header hunt, running checksum, payload capture
   rcfp_parse #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_parse (
      .clock    (clock),
      .reset    (reset),
      .vld      (in_vld),
      .rx_byte  (in_byte),
      .out_free (out_free),
      .consume  (consume),
      .evt      (evt),
      .pend     (pend)
   );

   // held channel values are the result payload; refreshed on a good checksum
   rcfp_out_reg #(
      .CHANNELS (CHANNELS)
   ) u_out (
      .clock             (clock),
      .reset             (reset),
      .evt               (evt),
      .pend              (pend),
      .out_free          (out_free),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_ok      (rsp_frame_ok),
      .chan              (chan),
      .rsp_failsafe_bits (rsp_failsafe_bits)
   );

   assign rsp_chan_0 = chan[0];
   assign rsp_chan_1 = chan[1];
   assign rsp_chan_2 = chan[2];
   assign rsp_chan_3 = chan[3];
   assign rsp_chan_4 = chan[4];
   assign rsp_chan_5 = chan[5];
   assign rsp_chan_6 = chan[6];
   assign rsp_chan_7 = chan[7];

endmodule

/* src/rcfp_in_reg.sv */
// rcfp_in_reg: input register for received bytes, with stall back to the source.
// Depends on rcfp_pkg.
module rcfp_in_reg
   import rcfp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  byte_type req_rx_byte,
   input  logic     consume,    // parser takes the held beat this cycle
   output logic     vld,
   output byte_type rx_byte
);

   logic     vld_ff, vld_in;
   byte_type byte_ff, byte_in;

   assign req_stall = vld_ff && !consume;

   always_comb begin
      vld_in  = vld_ff;
      byte_in = byte_ff;
      if (!req_stall) begin
         vld_in = req_valid;
         if (req_valid) begin
            byte_in = req_rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign vld     = vld_ff;
   assign rx_byte = byte_ff;

endmodule

/* src/rcfp_parse.sv */
// rcfp_parse: header hunt, byte position, running checksum and payload byte store.
// Depends on rcfp_pkg.
module rcfp_parse
   import rcfp_pkg::*;
#(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          vld,
   input  byte_type      rx_byte,
   input  logic          out_free,   // result slot can take a beat this cycle
   output logic          consume,
   output frame_evt_type evt,
   output byte_type      pend [PEND_DEPTH]
);

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
   localparam logic [POS_W-1:0] CSUM_LO  = POS_W'(FRAME_BYTES - 2);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      sum_ff, sum_in;
   byte_type         lo_ff, lo_in;
   byte_type         pend_ff [PEND_DEPTH];
   logic             is_last, mid;

   assign is_last = (pos_ff == LAST_POS);
   // final byte needs the result slot; every other byte goes straight through
   assign consume = vld && (!is_last || out_free);
   assign mid     = (pos_ff >= POS_W'(PEND_BASE)) && (pos_ff < CSUM_LO);

   always_comb begin
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      lo_in    = lo_ff;
      evt.done = 1'b0;
      evt.ok   = 1'b0;
      if (consume) begin
         priority if (pos_ff == '0) begin
            if (rx_byte == HDR_FIRST) begin
               sum_in = SUM_START - {8'h00, HDR_FIRST};
               pos_in = POS_W'(1);
            end
         end else if (pos_ff == POS_W'(1)) begin
            // bad second header drops back to hunting, byte not retested
            if (rx_byte == HDR_SECOND) begin
               sum_in = sum_ff - {8'h00, rx_byte};
               pos_in = POS_W'(2);
            end else begin
               pos_in = '0;
            end
         end else if (mid) begin
            sum_in = sum_ff - {8'h00, rx_byte};
            pos_in = pos_ff + POS_W'(1);
         end else if (pos_ff == CSUM_LO) begin
            lo_in  = rx_byte;
            pos_in = pos_ff + POS_W'(1);
         end else begin
            evt.done = 1'b1;
            evt.ok   = ({rx_byte, lo_ff} == sum_ff);
            pos_in   = '0;
            sum_in   = SUM_START;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sum_ff <= SUM_START;
         lo_ff  <= '0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
         lo_ff  <= lo_in;
      end
   end

   // payload bytes 2..17, each slot written at its own position
   for (genvar i = 0; i < PEND_DEPTH; i++) begin : g_pend
      always_ff @(posedge clock) begin
         if (consume && mid && (pos_ff == POS_W'(i + PEND_BASE))) begin
            pend_ff[i] <= rx_byte;
         end
      end
      assign pend[i] = pend_ff[i];
   end

endmodule

/* src/rcfp_out_reg.sv */
// rcfp_out_reg: result register; held channels and failsafe double as the payload.
// Depends on rcfp_pkg.
module rcfp_out_reg
   import rcfp_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  frame_evt_type evt,
   input  byte_type      pend [PEND_DEPTH],
   output logic          out_free,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic          rsp_frame_ok,
   output chan_type      chan [CHAN_FIELDS],
   output logic [3:0]    rsp_failsafe_bits
);

   logic       vld_ff, vld_in;
   logic       ok_ff;
   chan_type   chan_ff [CHAN_FIELDS];
   logic [3:0] fs_ff;
   logic       take;

   assign out_free = !vld_ff || !rsp_stall;
   assign take     = evt.done && evt.ok;

   always_comb begin
      vld_in = vld_ff;
      if (evt.done) begin
         vld_in = 1'b1;
      end else if (!rsp_stall) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         fs_ff  <= '0;
      end else begin
         vld_ff <= vld_in;
         if (take) begin
            fs_ff <= pend[FS_PEND_IDX][7:4];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (evt.done) begin
         ok_ff <= evt.ok;
      end
   end

   // channels beyond CHANNELS keep their reset value
   for (genvar k = 0; k < CHAN_FIELDS; k++) begin : g_chan
      always_ff @(posedge clock) begin
         if (reset) begin
            chan_ff[k] <= '0;
         end else if (take && (k < CHANNELS)) begin
            chan_ff[k] <= {pend[2 * k + 1], pend[2 * k]};
         end
      end
      assign chan[k] = chan_ff[k];
   end

   assign rsp_valid         = vld_ff;
   assign rsp_frame_ok      = ok_ff;
   assign rsp_failsafe_bits = fs_ff;

endmodule

/* sim/rcfp_frame_check.sv */
`timescale 1ns / 100ps
// rcfp_frame_check: follows the byte beats into the parser, predicts each frame result
// and compares it with the result beats. Depends on rcfp_pkg.
module rcfp_frame_check
   import rcfp_pkg::*;
#(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF,
   parameter int CHANNELS    = CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_frame_ok,
   input  logic [15:0] rsp_chan_0,
   input  logic [15:0] rsp_chan_1,
   input  logic [15:0] rsp_chan_2,
   input  logic [15:0] rsp_chan_3,
   input  logic [15:0] rsp_chan_4,
   input  logic [15:0] rsp_chan_5,
   input  logic [15:0] rsp_chan_6,
   input  logic [15:0] rsp_chan_7,
   input  logic [3:0]  rsp_failsafe_bits,
   output int          frames_owed,
   output int          bad_count
);

   localparam int LAST = FRAME_BYTES - 1;

   typedef struct packed {
      logic                          ok;
      logic [CHAN_FIELDS-1:0][15:0] chan;
      logic [3:0]                    fs;
   } frame_res_type;

   frame_res_type frames_due[$];

   // parser image
   logic [POS_W-1:0]             pos;
   logic [15:0]                  csum;
   byte_type                     sum_lo;
   byte_type                     payload [PEND_DEPTH];
   logic [CHAN_FIELDS-1:0][15:0] chan_hold;
   logic [3:0]                   fs_hold;

   initial begin
      bad_count   = 0;
      frames_owed = 0;
   end

   task automatic note_bad(input string what, input int got, input int want);
      $display("%0t mismatch %s: got %h, want %h", $time, what, got, want);
      bad_count++;
   endtask

   // one byte beat through the frame hunt; a final byte queues a result
   task automatic decode_byte(input byte_type b);
      frame_res_type res;
      int            k;
      if (pos == '0) begin
         if (b == HDR_FIRST) begin
            csum = SUM_START - b;
            pos  = POS_W'(1);
         end
      end else if (pos == POS_W'(1)) begin
         // a bad second header is dropped, not retried as a first header
         if (b == HDR_SECOND) begin
            csum = csum - b;
            pos  = POS_W'(2);
         end else begin
            pos = '0;
         end
      end else if (int'(pos) < LAST - 1) begin
         if (int'(pos) - PEND_BASE < PEND_DEPTH)
            payload[int'(pos) - PEND_BASE] = b;
         csum = csum - b;
         pos  = pos + 1'b1;
      end else if (int'(pos) == LAST - 1) begin
         sum_lo = b;
         pos    = pos + 1'b1;
      end else begin
         res.ok = ({b, sum_lo} == csum);
         if (res.ok) begin
            for (k = 0; k < CHANNELS && k < CHAN_FIELDS; k++)
               chan_hold[k] = {payload[(2 * k + 1) % PEND_DEPTH],
                               payload[(2 * k) % PEND_DEPTH]};
            fs_hold = payload[FS_PEND_IDX][7:4];
         end
         res.chan = chan_hold;
         res.fs   = fs_hold;
         frames_due.push_back(res);
         pos  = '0;
         csum = SUM_START;
      end
   endtask

   always @(posedge clock) begin : watch
      frame_res_type                want;
      logic [CHAN_FIELDS-1:0][15:0] got_ch;
      int                           k;
      if (reset) begin
         pos       = '0;
         csum      = SUM_START;
         sum_lo    = '0;
         chan_hold = '0;
         fs_hold   = '0;
         foreach (payload[i]) payload[i] = '0;
         frames_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (frames_due.size() == 0) begin
               note_bad("result beat with no frame due", 1, 0);
            end else begin
               want   = frames_due.pop_front();
               got_ch = {rsp_chan_7, rsp_chan_6, rsp_chan_5, rsp_chan_4,
                         rsp_chan_3, rsp_chan_2, rsp_chan_1, rsp_chan_0};
               if (rsp_frame_ok !== want.ok)
                  note_bad("frame_ok", rsp_frame_ok, want.ok);
               for (k = 0; k < CHAN_FIELDS; k++)
                  if (got_ch[k] !== want.chan[k])
                     note_bad($sformatf("chan_%0d", k), got_ch[k], want.chan[k]);
               if (rsp_failsafe_bits !== want.fs)
                  note_bad("failsafe_bits", rsp_failsafe_bits, want.fs);
            end
         end
         if (req_valid && !req_stall)
            decode_byte(req_rx_byte);
      end
      frames_owed = frames_due.size();
   end

endmodule

/* sim/rc_receiver_frame_parser_top_tb.sv */
`timescale 1ns / 100ps
// rc_receiver_frame_parser_top_tb: byte stream stimulus, handshake pacing and verdict
// for the frame parser. Depends on rcfp_pkg, the parser RTL and rcfp_frame_check.
module rc_receiver_frame_parser_top_tb;
   import rcfp_pkg::*;

   localparam int FRAME_BYTES = FRAME_BYTES_DEF;
   localparam int CHANNELS    = CHANNELS_DEF;
   localparam int BYTE_TARGET = 1300;  // byte beats to reach before the random part stops
   localparam int IDLE_PCT    = 34;    // idle / stall odds per cycle, percent
   localparam int CALM_FROM   = 500;   // byte window with no idling on either side
   localparam int CALM_TO     = 800;

   // payload fill styles for generated frames
   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_HEADERS} fill_kind_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic        rsp_frame_ok;
   logic [15:0] rsp_chan_0, rsp_chan_1, rsp_chan_2, rsp_chan_3;
   logic [15:0] rsp_chan_4, rsp_chan_5, rsp_chan_6, rsp_chan_7;
   logic [3:0]  rsp_failsafe_bits;

   int bytes_sent = 0;
   bit calm       = 1'b0;   // suppresses idling on both sides
   int frames_owed;
   int bad_count;

   rc_receiver_frame_parser_top #(
      .FRAME_BYTES (FRAME_BYTES),
      .CHANNELS    (CHANNELS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_ok      (rsp_frame_ok),
      .rsp_chan_0        (rsp_chan_0),
      .rsp_chan_1        (rsp_chan_1),
      .rsp_chan_2        (rsp_chan_2),
      .rsp_chan_3        (rsp_chan_3),
      .rsp_chan_4        (rsp_chan_4),
      .rsp_chan_5        (rsp_chan_5),
      .rsp_chan_6        (rsp_chan_6),
      .rsp_chan_7        (rsp_chan_7),
      .rsp_failsafe_bits (rsp_failsafe_bits)
   );

   // watches both channels, predicts each frame result and counts mismatches
   rcfp_frame_check #(
      .FRAME_BYTES (FRAME_BYTES),
      .CHANNELS    (CHANNELS)
   ) frame_chk (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_ok      (rsp_frame_ok),
      .rsp_chan_0        (rsp_chan_0),
      .rsp_chan_1        (rsp_chan_1),
      .rsp_chan_2        (rsp_chan_2),
      .rsp_chan_3        (rsp_chan_3),
      .rsp_chan_4        (rsp_chan_4),
      .rsp_chan_5        (rsp_chan_5),
      .rsp_chan_6        (rsp_chan_6),
      .rsp_chan_7        (rsp_chan_7),
      .rsp_failsafe_bits (rsp_failsafe_bits),
      .frames_owed       (frames_owed),
      .bad_count         (bad_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop; a healthy run needs a few tens of microseconds
   initial begin
      #2_000_000;
      $display("FAIL rc_receiver_frame_parser_top");
      $finish;
   end

   // result side back-pressure, changed at the falling edge like every input
   always @(negedge clock) begin
      rsp_stall <= !reset && !calm && ($urandom_range(99) < IDLE_PCT);
   end

   // One byte beat. Random idle cycles come first (valid low); then the byte is
   // held until a rising edge sees valid high and stall low. Returns at the
   // following falling edge with valid still high, so back-to-back beats never
   // drop valid in between.
   task automatic put_byte(input byte_type b);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Builds a full frame: headers, payload in the given style, then the checksum
   // (0xFFFF minus every byte before it, low byte first). A spoiled frame gets
   // one bit flipped past the headers, which always breaks the checksum. Only
   // the first `keep` bytes go out, so a short keep makes a truncated frame.
   task automatic send_frame(input fill_kind_type fill, input bit spoil, input int keep);
      byte_type    frm [FRAME_BYTES];
      logic [15:0] csum;
      int          i;
      int          spot;
      frm[0] = HDR_FIRST;
      frm[1] = HDR_SECOND;
      for (i = PEND_BASE; i < FRAME_BYTES - 2; i++) begin
         case (fill)
            FILL_ZERO:    frm[i] = 8'h00;
            FILL_ONES:    frm[i] = 8'hFF;
            FILL_HEADERS: frm[i] = $urandom_range(1) ? HDR_FIRST : HDR_SECOND;
            default:      frm[i] = 8'($urandom_range(255));
         endcase
      end
      csum = SUM_START;
      for (i = 0; i < FRAME_BYTES - 2; i++)
         csum = csum - frm[i];
      frm[FRAME_BYTES-2] = csum[7:0];
      frm[FRAME_BYTES-1] = csum[15:8];
      if (spoil) begin
         spot      = $urandom_range(FRAME_BYTES - 1, PEND_BASE);
         frm[spot] = frm[spot] ^ (8'h01 << $urandom_range(7));
      end
      for (i = 0; i < keep; i++)
         put_byte(frm[i]);
   endtask

   initial begin
      // hunt checks: stray bytes and a lone second header are ignored; a repeated
      // first header in the second slot restarts the hunt and is not retried, so
      // the 0x40 right after it must not start a frame
      byte_type      hunt_seq [12] = '{8'h00, 8'hFF, HDR_SECOND, HDR_FIRST, HDR_FIRST,
                                       HDR_SECOND, HDR_FIRST, 8'hFF, HDR_FIRST, 8'h00,
                                       8'hA5, 8'h5A};
      fill_kind_type fill;
      int            pick;
      int            n;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (hunt_seq[i]) put_byte(hunt_seq[i]);

      // good frame, then a bad one that must hold its channels, then both extremes
      send_frame(FILL_RANDOM, 1'b0, FRAME_BYTES);
      send_frame(FILL_RANDOM, 1'b1, FRAME_BYTES);
      send_frame(FILL_ONES,   1'b0, FRAME_BYTES);
      send_frame(FILL_ZERO,   1'b0, FRAME_BYTES);

      // random part: mostly clean frames with random payload, plus bad checksums,
      // header-heavy noise and truncated frames that swallow what follows
      while (bytes_sent < BYTE_TARGET) begin
         calm = (bytes_sent >= CALM_FROM && bytes_sent < CALM_TO);
         fill = ($urandom_range(9) < 7) ? FILL_RANDOM : fill_kind_type'($urandom_range(3));
         pick = $urandom_range(99);
         if (pick < 60) begin
            send_frame(fill, 1'b0, FRAME_BYTES);
         end else if (pick < 75) begin
            send_frame(fill, 1'b1, FRAME_BYTES);
         end else if (pick < 87) begin
            n = $urandom_range(6, 1);
            repeat (n)
               put_byte(($urandom_range(3) == 0) ? HDR_FIRST : 8'($urandom_range(255)));
         end else begin
            send_frame(fill, 1'b0, $urandom_range(FRAME_BYTES - 1, 1));
         end
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      // drain: every predicted frame result back, then a short tail for strays
      while (frames_owed != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      if (bad_count == 0)
         $display("PASS rc_receiver_frame_parser_top");
      else
         $display("FAIL rc_receiver_frame_parser_top");
      $finish;
   end

endmodule
